// ===== hdl/brl_pkg.sv =====
// Shared constants and types for the line segment rasterizer.
package brl_pkg;

  localparam int COORD_BITS = 6;
  localparam int COLOR_BITS = 24;
  localparam int ERR_BITS   = COORD_BITS + 3;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } brl_state_t;

  typedef struct packed {
    logic load;
    logic advance;
  } brl_cmd_t;

  typedef struct packed {
    logic last;
  } brl_stat_t;

endpackage

// ===== hdl/brl_if.sv =====
// Channel interfaces for line segments in and pixels out.
interface brl_seg_if;
  import brl_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] start_x;
  logic [COORD_BITS-1:0] start_y;
  logic [COORD_BITS-1:0] end_x;
  logic [COORD_BITS-1:0] end_y;
  logic [COLOR_BITS-1:0] pen_color;

  modport source (output valid, start_x, start_y, end_x, end_y, pen_color, input ready);
  modport sink (input valid, start_x, start_y, end_x, end_y, pen_color, output ready);
endinterface

interface brl_pix_if;
  import brl_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] pixel_x;
  logic [COORD_BITS-1:0] pixel_y;
  logic [COLOR_BITS-1:0] pixel_color;
  logic                  last_pixel;

  modport source (output valid, pixel_x, pixel_y, pixel_color, last_pixel, input ready);
  modport sink (input valid, pixel_x, pixel_y, pixel_color, last_pixel, output ready);
endinterface

// ===== hdl/brl_ctrl.sv =====
// Controller state machine that sequences segment setup and pixel stepping.
module brl_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  brl_pkg::brl_stat_t stat,
  output brl_pkg::brl_cmd_t  cmd
);
  import brl_pkg::*;

  brl_state_t state_r;
  brl_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    cmd.load    = 1'b0;
    cmd.advance = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.advance = 1'b1;
          if (stat.last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/brl_dp.sv =====
// Datapath holding the segment setup, the error term and the current pixel.
module brl_dp (
  input  logic                           clk,
  input  brl_pkg::brl_cmd_t              cmd,
  output brl_pkg::brl_stat_t             stat,
  input  logic [brl_pkg::COORD_BITS-1:0] start_x,
  input  logic [brl_pkg::COORD_BITS-1:0] start_y,
  input  logic [brl_pkg::COORD_BITS-1:0] end_x,
  input  logic [brl_pkg::COORD_BITS-1:0] end_y,
  input  logic [brl_pkg::COLOR_BITS-1:0] pen_color,
  output logic [brl_pkg::COORD_BITS-1:0] pixel_x,
  output logic [brl_pkg::COORD_BITS-1:0] pixel_y,
  output logic [brl_pkg::COLOR_BITS-1:0] pixel_color,
  output logic                           last_pixel
);
  import brl_pkg::*;

  logic                       swapped_r;
  logic                       up_r;
  logic [COORD_BITS-1:0]      major_r;
  logic [COORD_BITS-1:0]      minor_r;
  logic [COORD_BITS-1:0]      end_r;
  logic [COORD_BITS-1:0]      span_r;
  logic [COORD_BITS:0]        inc_r;
  logic signed [ERR_BITS-1:0] err_r;
  logic [COLOR_BITS-1:0]      color_r;

  logic signed [COORD_BITS:0] dx;
  logic signed [COORD_BITS:0] dy;
  logic [COORD_BITS-1:0]      adx;
  logic [COORD_BITS-1:0]      ady;
  logic                       swap;
  logic                       rev;
  logic                       up;
  logic [COORD_BITS-1:0]      a_maj;
  logic [COORD_BITS-1:0]      a_min;
  logic [COORD_BITS-1:0]      b_maj;
  logic [COORD_BITS-1:0]      b_min;
  logic [COORD_BITS-1:0]      p_maj;
  logic [COORD_BITS-1:0]      p_min;
  logic [COORD_BITS-1:0]      q_maj;
  logic [COORD_BITS-1:0]      q_min;
  logic [COORD_BITS-1:0]      dmin;

  logic signed [ERR_BITS-1:0] err_sum;
  logic signed [ERR_BITS-1:0] span_ext;
  logic signed [ERR_BITS-1:0] span2;
  logic                       minor_step;

  // The steeper axis becomes the major axis, and endpoints are ordered along it.
  always_comb begin
    dx    = $signed({1'b0, end_x}) - $signed({1'b0, start_x});
    dy    = $signed({1'b0, end_y}) - $signed({1'b0, start_y});
    adx   = dx[COORD_BITS] ? COORD_BITS'(-dx) : COORD_BITS'(dx);
    ady   = dy[COORD_BITS] ? COORD_BITS'(-dy) : COORD_BITS'(dy);
    swap  = adx < ady;
    a_maj = swap ? start_y : start_x;
    a_min = swap ? start_x : start_y;
    b_maj = swap ? end_y : end_x;
    b_min = swap ? end_x : end_y;
    rev   = a_maj > b_maj;
    p_maj = rev ? b_maj : a_maj;
    p_min = rev ? b_min : a_min;
    q_maj = rev ? a_maj : b_maj;
    q_min = rev ? a_min : b_min;
    up    = q_min > p_min;
    dmin  = up ? (q_min - p_min) : (p_min - q_min);
  end

  always_comb begin
    err_sum    = err_r + $signed({2'b00, inc_r});
    span_ext   = $signed({3'b000, span_r});
    span2      = $signed({2'b00, span_r, 1'b0});
    minor_step = err_sum > span_ext;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      swapped_r <= swap;
      up_r      <= up;
      major_r   <= p_maj;
      minor_r   <= p_min;
      end_r     <= q_maj;
      span_r    <= q_maj - p_maj;
      inc_r     <= {dmin, 1'b0};
      err_r     <= '0;
      color_r   <= pen_color;
    end else if (cmd.advance) begin
      major_r <= major_r + COORD_BITS'(1);
      if (minor_step) begin
        minor_r <= up_r ? (minor_r + COORD_BITS'(1)) : (minor_r - COORD_BITS'(1));
        err_r   <= err_sum - span2;
      end else begin
        err_r <= err_sum;
      end
    end
  end

  assign stat.last   = major_r == end_r;
  assign pixel_x     = swapped_r ? minor_r : major_r;
  assign pixel_y     = swapped_r ? major_r : minor_r;
  assign pixel_color = color_r;
  assign last_pixel  = stat.last;

endmodule

// ===== hdl/bresenham_line_rasterizer.sv =====
// Top level of the line segment rasterizer.
//
//   Channel   Direction  Transaction
//   in_seg    input      one segment: two endpoints and a pen color
//   out_pix   output     one pixel: x, y, color and a last flag
//
// A segment takes a setup step and then gives one pixel per cycle while out_pix
// is ready, 1 to 64 pixels in all, as one stepping register set serves it alone.
// A new segment is taken only after the last pixel of the previous one is taken.
// A stall on out_pix holds the current pixel and its error term.
// Reset returns the controller to idle; the datapath registers are not reset.
module bresenham_line_rasterizer (
  input logic       clk,
  input logic       rst_n,
  brl_seg_if.sink   in_seg,
  brl_pix_if.source out_pix
);
  import brl_pkg::*;

  brl_cmd_t  cmd;
  brl_stat_t stat;

  brl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_seg.valid),
    .in_ready  (in_seg.ready),
    .out_valid (out_pix.valid),
    .out_ready (out_pix.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  brl_dp u_dp (
    .clk         (clk),
    .cmd         (cmd),
    .stat        (stat),
    .start_x     (in_seg.start_x),
    .start_y     (in_seg.start_y),
    .end_x       (in_seg.end_x),
    .end_y       (in_seg.end_y),
    .pen_color   (in_seg.pen_color),
    .pixel_x     (out_pix.pixel_x),
    .pixel_y     (out_pix.pixel_y),
    .pixel_color (out_pix.pixel_color),
    .last_pixel  (out_pix.last_pixel)
  );

endmodule
